// File: hdl/rpc_pkg.sv
`default_nettype none

package rpc_pkg;

    localparam int PIXEL_W = 10;
    localparam int FRAME_W = 31;
    localparam int SUM_W = 32;
    localparam int WAVE_W = 16;
    localparam int HUE_W = 8;
    localparam int CHAN_W = 8;

    localparam int MOD_STAGES = SUM_W;
    localparam int HUE_STAGES = HUE_W;
    localparam int LATENCY = MOD_STAGES + HUE_STAGES + 3;

    localparam logic [WAVE_W-1:0] WAVE_RESET = 16'd32;
    localparam logic [WAVE_W-1:0] WAVE_MIN = 16'd1;

    localparam logic [CHAN_W-1:0] SEG_ONE = 8'd85;
    localparam logic [CHAN_W-1:0] SEG_TWO = 8'd170;
    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel_index;
        logic [FRAME_W-1:0] frame_index;
    } pixel_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } color_t;

endpackage

`default_nettype wire

// File: hdl/rainbow_pixel_color.sv
// Channel   | Direction | Handshake                 | Payload
// request   | in        | start, busy               | pixel (pixel_index, frame_index)
// result    | out       | color_valid strobe        | color (red, green, blue)
// config    | in        | cfg_valid, cfg_ready      | cfg_data (wavelength)
//
// A request is taken in every cycle; busy stays low and cfg_ready stays high.
// Each result passes, in order, through the input register, the 32-stage
// remainder pipeline, the scaling register, the 8-stage hue divider and the wheel register.
// Reset clears every valid bit and loads a wavelength of 32.
// The receiver takes each result in its single strobe cycle.
`default_nettype none

module rainbow_pixel_color (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire rpc_pkg::pixel_t                pixel,
    output logic                                color_valid,
    output rpc_pkg::color_t                     color,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [rpc_pkg::WAVE_W-1:0]     cfg_data
);

    localparam int SW = rpc_pkg::SUM_W;
    localparam int WW = rpc_pkg::WAVE_W;

    logic [WW-1:0] wave_reg;
    logic [WW-1:0] wave_next;
    logic          sum_valid_reg;
    logic [SW-1:0] sum_reg;
    logic [SW-1:0] sum_next;

    logic          pos_valid;
    logic [WW-1:0] pos;
    logic          hue_valid;
    logic [rpc_pkg::HUE_W-1:0] hue;

    assign busy = 1'b0;
    assign cfg_ready = 1'b1;

    assign wave_next = (cfg_data == '0) ? rpc_pkg::WAVE_MIN : cfg_data;
    assign sum_next = {{(SW - rpc_pkg::PIXEL_W){1'b0}}, pixel.pixel_index}
                    + {{(SW - rpc_pkg::FRAME_W){1'b0}}, pixel.frame_index};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_reg <= rpc_pkg::WAVE_RESET;
            sum_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                wave_reg <= wave_next;
            end
            sum_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
    end

    rpc_mod_pipe u_mod (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (sum_valid_reg),
        .in_sum     (sum_reg),
        .wavelength (wave_reg),
        .out_valid  (pos_valid),
        .out_pos    (pos)
    );

    rpc_hue_pipe u_hue (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (pos_valid),
        .in_pos     (pos),
        .wavelength (wave_reg),
        .out_valid  (hue_valid),
        .out_hue    (hue)
    );

    rpc_wheel u_wheel (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (hue_valid),
        .in_hue    (hue),
        .out_valid (color_valid),
        .out_color (color)
    );

endmodule

`default_nettype wire

// File: hdl/rpc_mod_pipe.sv
`default_nettype none

module rpc_mod_pipe (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    input  wire logic [rpc_pkg::SUM_W-1:0]      in_sum,
    input  wire logic [rpc_pkg::WAVE_W-1:0]     wavelength,
    output logic                                out_valid,
    output logic [rpc_pkg::WAVE_W-1:0]          out_pos
);

    localparam int N = rpc_pkg::MOD_STAGES;
    localparam int SW = rpc_pkg::SUM_W;
    localparam int WW = rpc_pkg::WAVE_W;

    logic          valid_reg [N];
    logic [WW-1:0] rem_reg   [N];
    logic [SW-1:0] dvd_reg   [N];

    logic          valid_next [N];
    logic [WW-1:0] rem_next   [N];
    logic [SW-1:0] dvd_next   [N];

    // One restoring step per stage: bring in the next dividend bit and
    // subtract the wavelength when the partial remainder reaches it.
    always_comb
    begin
        logic [WW-1:0] rem_src;
        logic [SW-1:0] dvd_src;
        logic [WW:0]   trial;
        logic [WW:0]   diff;
        for (int k = 0; k < N; k++)
        begin
            if (k == 0)
            begin
                valid_next[k] = in_valid;
                rem_src = '0;
                dvd_src = in_sum;
            end
            else
            begin
                valid_next[k] = valid_reg[k-1];
                rem_src = rem_reg[k-1];
                dvd_src = dvd_reg[k-1];
            end
            trial = {rem_src, dvd_src[SW-1]};
            diff = trial - {1'b0, wavelength};
            if (trial >= {1'b0, wavelength})
            begin
                rem_next[k] = diff[WW-1:0];
            end
            else
            begin
                rem_next[k] = trial[WW-1:0];
            end
            dvd_next[k] = {dvd_src[SW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < N; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else
        begin
            for (int k = 0; k < N; k++)
            begin
                valid_reg[k] <= valid_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < N; k++)
        begin
            rem_reg[k] <= rem_next[k];
            dvd_reg[k] <= dvd_next[k];
        end
    end

    assign out_valid = valid_reg[N-1];
    assign out_pos = rem_reg[N-1];

endmodule

`default_nettype wire

// File: hdl/rpc_hue_pipe.sv
`default_nettype none

module rpc_hue_pipe (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    input  wire logic [rpc_pkg::WAVE_W-1:0]     in_pos,
    input  wire logic [rpc_pkg::WAVE_W-1:0]     wavelength,
    output logic                                out_valid,
    output logic [rpc_pkg::HUE_W-1:0]           out_hue
);

    localparam int N = rpc_pkg::HUE_STAGES;
    localparam int WW = rpc_pkg::WAVE_W;
    localparam int HW = rpc_pkg::HUE_W;
    localparam int PW = WW + HW;

    logic          scale_valid_reg;
    logic [PW-1:0] scale_reg;
    logic [PW-1:0] scale_next;

    logic          valid_reg [N];
    logic [WW-1:0] rem_reg   [N];
    logic [HW-1:0] quo_reg   [N];

    logic          valid_next [N];
    logic [WW-1:0] rem_next   [N];
    logic [HW-1:0] quo_next   [N];

    // Position times 255, formed as a shift and a subtract.
    assign scale_next = {in_pos, {HW{1'b0}}} - {{HW{1'b0}}, in_pos};

    // The product is below 256 times the wavelength, so its upper part is
    // already a valid partial remainder and the quotient fits in eight bits.
    // Quotient bits shift in at the bottom as dividend bits leave the top.
    always_comb
    begin
        logic [WW-1:0] rem_src;
        logic [HW-1:0] quo_src;
        logic [WW:0]   trial;
        logic [WW:0]   diff;
        logic          ge;
        for (int k = 0; k < N; k++)
        begin
            if (k == 0)
            begin
                valid_next[k] = scale_valid_reg;
                rem_src = scale_reg[PW-1:HW];
                quo_src = scale_reg[HW-1:0];
            end
            else
            begin
                valid_next[k] = valid_reg[k-1];
                rem_src = rem_reg[k-1];
                quo_src = quo_reg[k-1];
            end
            trial = {rem_src, quo_src[HW-1]};
            diff = trial - {1'b0, wavelength};
            ge = (trial >= {1'b0, wavelength});
            if (ge)
            begin
                rem_next[k] = diff[WW-1:0];
            end
            else
            begin
                rem_next[k] = trial[WW-1:0];
            end
            quo_next[k] = {quo_src[HW-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_valid_reg <= 1'b0;
            for (int k = 0; k < N; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else
        begin
            scale_valid_reg <= in_valid;
            for (int k = 0; k < N; k++)
            begin
                valid_reg[k] <= valid_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        scale_reg <= scale_next;
        for (int k = 0; k < N; k++)
        begin
            rem_reg[k] <= rem_next[k];
            quo_reg[k] <= quo_next[k];
        end
    end

    assign out_valid = valid_reg[N-1];
    assign out_hue = quo_reg[N-1];

endmodule

`default_nettype wire

// File: hdl/rpc_wheel.sv
`default_nettype none

module rpc_wheel (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    input  wire logic [rpc_pkg::HUE_W-1:0]      in_hue,
    output logic                                out_valid,
    output rpc_pkg::color_t                     out_color
);

    localparam int CW = rpc_pkg::CHAN_W;

    logic            valid_reg;
    rpc_pkg::color_t color_reg;
    rpc_pkg::color_t color_next;

    logic [CW-1:0] wheel_pos;
    logic [CW-1:0] offset;
    logic [CW-1:0] ramp;

    assign wheel_pos = ~in_hue;

    always_comb
    begin
        if (wheel_pos < rpc_pkg::SEG_ONE)
        begin
            offset = wheel_pos;
        end
        else if (wheel_pos < rpc_pkg::SEG_TWO)
        begin
            offset = wheel_pos - rpc_pkg::SEG_ONE;
        end
        else
        begin
            offset = wheel_pos - rpc_pkg::SEG_TWO;
        end
        ramp = {offset[CW-2:0], 1'b0} + offset;

        if (wheel_pos < rpc_pkg::SEG_ONE)
        begin
            color_next.red = rpc_pkg::CHAN_MAX - ramp;
            color_next.green = '0;
            color_next.blue = ramp;
        end
        else if (wheel_pos < rpc_pkg::SEG_TWO)
        begin
            color_next.red = '0;
            color_next.green = ramp;
            color_next.blue = rpc_pkg::CHAN_MAX - ramp;
        end
        else
        begin
            color_next.red = ramp;
            color_next.green = rpc_pkg::CHAN_MAX - ramp;
            color_next.blue = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        color_reg <= color_next;
    end

    assign out_valid = valid_reg;
    assign out_color = color_reg;

endmodule

`default_nettype wire

// File: hdl/rpc_checker.sv
`default_nettype none

module rpc_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic               busy,
    input  wire logic               color_valid,
    input  wire rpc_pkg::color_t    color
);

    // Every request comes out exactly once, after the fixed latency.
    a_request_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(rpc_pkg::LATENCY) color_valid)
        else $error("request produced no result at the expected cycle");

    a_result_from_request: assert property (@(posedge clk) disable iff (!rst_n)
        color_valid |-> $past(start && !busy, rpc_pkg::LATENCY))
        else $error("result without a matching request");

    // Every wheel color has at least one dark channel and the others sum to full scale.
    a_color_sum: assert property (@(posedge clk) disable iff (!rst_n)
        color_valid |-> (({2'b00, color.red} + {2'b00, color.green}
                          + {2'b00, color.blue}) == 10'd255))
        else $error("color channels do not sum to full scale");

    a_color_dark: assert property (@(posedge clk) disable iff (!rst_n)
        color_valid |-> ((color.red == '0) || (color.green == '0)
                         || (color.blue == '0)))
        else $error("no dark channel in wheel color");

endmodule

bind rainbow_pixel_color rpc_checker u_rpc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .color_valid (color_valid),
    .color       (color)
);

`default_nettype wire

// File: test/tb_rainbow_pixel_color.sv
`timescale 1ns / 100ps

module tb_rainbow_pixel_color;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MISMATCH_SHOWN = 10;
    localparam int SETTINGS_PER_PHASE = 4;
    localparam int PIXELS_PER_SETTING = 150;

    localparam int PW = rpc_pkg::PIXEL_W;
    localparam int FW = rpc_pkg::FRAME_W;
    localparam int SW = rpc_pkg::SUM_W;
    localparam int WW = rpc_pkg::WAVE_W;
    localparam int HW = rpc_pkg::HUE_W;
    localparam int CW = rpc_pkg::CHAN_W;

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    rpc_pkg::pixel_t pixel;
    logic color_valid;
    rpc_pkg::color_t color;
    logic cfg_valid;
    logic cfg_ready;
    logic [WW-1:0] cfg_data;

    rpc_pkg::color_t pending_colors[$];
    rpc_pkg::color_t wanted_color;
    logic [WW-1:0] wave_setting;
    int sender_idle_pct;
    int color_errors;
    int colors_checked;
    int pixels_sent;
    int wave_writes;
    int quiet_cycles;

    rainbow_pixel_color u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .pixel       (pixel),
        .color_valid (color_valid),
        .color       (color),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic rpc_pkg::color_t rainbow_color(input logic [PW-1:0] px,
                                                      input logic [FW-1:0] fr,
                                                      input logic [WW-1:0] wave);
        logic [SW-1:0] sum;
        logic [SW-1:0] wave_wide;
        logic [SW-1:0] pos;
        logic [SW-1:0] scaled;
        logic [SW-1:0] quotient;
        logic [HW-1:0] h;
        rpc_pkg::color_t c;
        sum = {{(SW - PW){1'b0}}, px} + {{(SW - FW){1'b0}}, fr};
        wave_wide = {{(SW - WW){1'b0}}, wave};
        pos = sum % wave_wide;
        scaled = pos * {{(SW - CW){1'b0}}, rpc_pkg::CHAN_MAX};
        quotient = scaled / wave_wide;
        h = rpc_pkg::CHAN_MAX - quotient[HW-1:0];
        if (h < rpc_pkg::SEG_ONE)
        begin
            c.red = rpc_pkg::CHAN_MAX - h * 8'd3;
            c.green = '0;
            c.blue = h * 8'd3;
        end
        else if (h < rpc_pkg::SEG_TWO)
        begin
            h = h - rpc_pkg::SEG_ONE;
            c.red = '0;
            c.green = h * 8'd3;
            c.blue = rpc_pkg::CHAN_MAX - h * 8'd3;
        end
        else
        begin
            h = h - rpc_pkg::SEG_TWO;
            c.red = h * 8'd3;
            c.green = rpc_pkg::CHAN_MAX - h * 8'd3;
            c.blue = '0;
        end
        return c;
    endfunction

    task automatic send_pixel(input logic [PW-1:0] px, input logic [FW-1:0] fr);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        pixel.pixel_index <= px;
        pixel.frame_index <= fr;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_colors.push_back(rainbow_color(px, fr, wave_setting));
        pixels_sent++;
    endtask

    task automatic write_wavelength(input logic [WW-1:0] value);
        start <= 1'b0;
        while (pending_colors.size() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        wave_setting = (value == '0) ? rpc_pkg::WAVE_MIN : value;
        wave_writes++;
    endtask

    task automatic test_default_wavelength;
        send_pixel('0, '0);
        send_pixel('1, '1);
        send_pixel(10'd31, '0);
        send_pixel('0, 31'd32);
        send_pixel(10'd1000, 31'h7FFF_FC00);
    endtask

    task automatic test_wheel_segments;
        int steps[8] = '{1, 84, 85, 86, 169, 170, 171, 255};
        write_wavelength(16'd255);
        foreach (steps[i])
            send_pixel(10'(255 - steps[i]), 31'(255 * (1000 + i)));
    endtask

    task automatic test_zero_wavelength;
        write_wavelength('0);
        send_pixel(10'd517, 31'h2AAA_5555);
        send_pixel('1, '1);
    endtask

    task automatic test_widest_wavelength;
        write_wavelength('1);
        send_pixel('1, '1);
        send_pixel('0, 31'd65534);
        send_pixel('0, 31'd65535);
    endtask

    task automatic test_random_pixels;
        logic [WW-1:0] waves[12];
        logic [FW-1:0] fr;
        int idle_by_phase[3] = '{8, 81, 0};
        waves = '{16'hFFFF, 16'd1, 16'd0, 16'd255, 16'd256, 16'd3,
                  16'($urandom_range(2, 64)), 16'($urandom_range(1, 65535)),
                  16'd2, 16'd1024, 16'($urandom_range(2, 64)),
                  16'($urandom_range(1, 65535))};
        for (int phase = 0; phase < 3; phase++)
        begin
            for (int k = 0; k < SETTINGS_PER_PHASE; k++)
            begin
                write_wavelength(waves[phase * SETTINGS_PER_PHASE + k]);
                sender_idle_pct = idle_by_phase[phase];
                for (int n = 0; n < PIXELS_PER_SETTING; n++)
                begin
                    case ($urandom_range(0, 3))
                        0: fr = 31'($urandom_range(0, 4095));
                        1: fr = 31'h7FFF_FFFF - 31'($urandom_range(0, 2047));
                        default: fr = 31'($urandom());
                    endcase
                    send_pixel(10'($urandom_range(0, 1023)), fr);
                end
                sender_idle_pct = 0;
            end
        end
        start <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && color_valid)
        begin
            if (pending_colors.size() == 0)
            begin
                color_errors++;
                if (color_errors <= MISMATCH_SHOWN)
                    $display("Unexpected color r=%0d g=%0d b=%0d", color.red, color.green,
                             color.blue);
            end
            else
            begin
                wanted_color = pending_colors.pop_front();
                colors_checked++;
                if (color.red !== wanted_color.red || color.green !== wanted_color.green ||
                    color.blue !== wanted_color.blue)
                begin
                    color_errors++;
                    if (color_errors <= MISMATCH_SHOWN)
                        $display({"Color mismatch: expected r=%0d g=%0d b=%0d, ",
                                  "got r=%0d g=%0d b=%0d"},
                                 wanted_color.red, wanted_color.green, wanted_color.blue,
                                 color.red, color.green, color.blue);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || color_valid || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout with %0d colors outstanding", pending_colors.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        start <= 1'b0;
        pixel <= '0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        wave_setting = rpc_pkg::WAVE_RESET;
        sender_idle_pct = 0;
        color_errors = 0;
        colors_checked = 0;
        pixels_sent = 0;
        wave_writes = 0;
        quiet_cycles = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_wavelength();
        test_wheel_segments();
        test_zero_wavelength();
        test_widest_wavelength();
        test_random_pixels();

        while (pending_colors.size() != 0)
            @(posedge clk);
        repeat (rpc_pkg::LATENCY + 5) @(posedge clk);
        if (pending_colors.size() != 0)
            color_errors++;

        $display("Sent %0d pixel requests over %0d wavelength writes; %0d colors checked.",
                 pixels_sent, wave_writes, colors_checked);
        $display("Errors found: %0d", color_errors);
        if (color_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
